[hw/rtl/bliu_pkg.sv]
// shared types, constants and widths for the bilinear integer upscaler
package bliu_pkg;

    localparam int PIXEL_BITS     = 16;
    localparam int COORD_W        = 13;
    localparam int ROW_WIDTH_W    = 11;
    localparam int SCALE_W        = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = ROW_WIDTH_W;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_SCALE      = 8;

    localparam int SC_W  = $clog2(MAX_SCALE + 1);
    localparam int DEN_W = 2 * SC_W;
    localparam int W_W   = 2 * SC_W + 1;
    localparam int N_W   = PIXEL_BITS + DEN_W;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = ROW_WIDTH_W'(640);
    localparam logic [SCALE_W-1:0]     SCALE_X_RST   = SCALE_W'(2);
    localparam logic [SCALE_W-1:0]     SCALE_Y_RST   = SCALE_W'(2);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_WIDTH = 2'd0,
        REG_SCALE_X   = 2'd1,
        REG_SCALE_Y   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ALU_HOLD = 2'd0,
        ALU_LOAD = 2'd1,
        ALU_MAC  = 2'd2,
        ALU_DIV  = 2'd3
    } alu_op_t;

    typedef struct packed {
        alu_op_t                op;
        logic [PIXEL_BITS-1:0]  coef;
        logic [W_W-1:0]         weight;
        logic [DEN_W-1:0]       denom;
    } alu_ctrl_t;

endpackage

[hw/rtl/bliu_if.sv]
// valid/ready channel interfaces for input pixels and interpolated results
interface bliu_pix_if
    import bliu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface bliu_res_if
    import bliu_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] value;
    logic [COORD_W-1:0]    out_x;
    logic [COORD_W-1:0]    out_y;
    logic                  last;

    modport source (output valid, output value, output out_x, output out_y, output last,
                    input ready);
    modport sink   (input valid, input value, input out_x, input out_y, input last,
                    output ready);
endinterface

[hw/rtl/bliu_line_buf.sv]
// previous-row line store with a fill count so unwritten entries read as zero
module bliu_line_buf
    import bliu_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      addr,
    input  logic [PIXEL_BITS-1:0]         wdata,
    output logic [PIXEL_BITS-1:0]         rdata
);
    localparam int FW = $clog2(DEPTH + 1);

    logic [PIXEL_BITS-1:0] mem_reg [DEPTH];
    logic [PIXEL_BITS-1:0] rdata_reg;
    logic                  hit_reg;
    logic [FW-1:0]         fill_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    // writes walk columns upward from zero, so the written entries form a prefix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                hit_reg <= (FW'(addr) < fill_reg);
            end
            if (wr_en && (FW'(addr) == fill_reg) && (fill_reg != FW'(DEPTH)))
            begin
                fill_reg <= fill_reg + FW'(1);
            end
        end
    end

    assign rdata = hit_reg ? rdata_reg : '0;

endmodule

[hw/rtl/bliu_alu.sv]
// shared multiply-accumulate and restoring-division step unit
module bliu_alu
    import bliu_pkg::*;
(
    input  logic                  clk,
    input  alu_ctrl_t             ctrl,
    output logic [PIXEL_BITS-1:0] quotient
);
    localparam int PW = PIXEL_BITS + W_W;

    logic [N_W-1:0]        acc_reg;
    logic [N_W-1:0]        dv_reg;
    logic [PIXEL_BITS-1:0] quo_reg;
    logic [PW-1:0]         prod;
    logic                  fits;

    assign prod = PW'(ctrl.coef) * PW'(ctrl.weight);
    assign fits = (acc_reg >= dv_reg);

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            ALU_LOAD:
            begin
                acc_reg <= N_W'(ctrl.denom);
                dv_reg  <= {ctrl.denom, {PIXEL_BITS{1'b0}}};
                quo_reg <= '0;
            end
            ALU_MAC:
            begin
                acc_reg <= acc_reg + N_W'(prod);
            end
            ALU_DIV:
            begin
                if (fits)
                begin
                    acc_reg <= acc_reg - dv_reg;
                end
                quo_reg <= {quo_reg[PIXEL_BITS-2:0], fits};
                dv_reg  <= dv_reg >> 1;
            end
            default:
            begin
            end
        endcase
    end

    assign quotient = quo_reg;

endmodule

[hw/rtl/bilinear_integer_upscaler.sv]
// bilinear integer upscaler: top level with counters, sequencer and config registers
//
// Pixels arrive in raster order on the pix channel; frame_start restarts the
// row and column counters at that pixel. Every pixel at row >= 1 and column >= 1
// closes a cell, and the block then sends scale_y * scale_x results on the res
// channel, row by row, each with its output coordinates; last marks the end
// of the cell's run. Pixels in the first row or column send nothing.
// One pixel is worked at a time: pix.ready is high only while idle.
// A pixel that closes no cell passes through the read state and returns to idle.
// A closing pixel then runs, for each result, a weight step, a multiply-accumulate
// step for each of the four corners and 16 division steps on the
// one shared arithmetic unit, then waits on the output register until taken.
// A stalled receiver holds the result in place and freezes the sequencer.
// Reset sets row_width 640 and both scales 2 and empties the line store at
// once: a fill count makes never-written columns read as zero, no clearing pass.
// Configuration writes through cfg_we/cfg_index/cfg_data act from the next pixel.
module bilinear_integer_upscaler
    import bliu_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bliu_pix_if.sink              pix,
    bliu_res_if.source            res
);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int CW1    = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int RW1    = $clog2(MAX_HEIGHT + 1);
    localparam int EW     = (ROW_WIDTH_W > CW1) ? ROW_WIDTH_W : CW1;
    localparam int PX_W   = CW + SC_W;
    localparam int PY_W   = RW + SC_W;
    localparam int STEP_W = $clog2(PIXEL_BITS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_WGT  = 6'b000100,
        S_MAC  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic [SCALE_W-1:0]     scale_x_reg;
    logic [SCALE_W-1:0]     scale_y_reg;

    logic [CW-1:0]          col_reg;
    logic [RW-1:0]          row_reg;
    logic [PIXEL_BITS-1:0]  left_cur_reg;
    logic [PIXEL_BITS-1:0]  left_abv_reg;
    logic [PIXEL_BITS-1:0]  px_reg;
    logic [CW-1:0]          cur_col_reg;
    logic [RW-1:0]          cur_row_reg;
    logic                   emit_reg;
    logic [SC_W-1:0]        sx_reg;
    logic [SC_W-1:0]        sy_reg;
    logic [DEN_W-1:0]       d_reg;
    logic [PIXEL_BITS-1:0]  coef_reg [4];
    logic [W_W-1:0]         w_reg [4];
    logic [COORD_W-1:0]     base_x_reg;
    logic [COORD_W-1:0]     base_y_reg;
    logic [SC_W-1:0]        i_reg;
    logic [SC_W-1:0]        j_reg;
    logic [1:0]             k_reg;
    logic [STEP_W-1:0]      step_reg;

    logic [SC_W-1:0]        sx_eff;
    logic [SC_W-1:0]        sy_eff;
    logic [EW-1:0]          rw_ext;
    logic [CW1-1:0]         width_eff;
    logic [CW-1:0]          col_cur;
    logic [RW-1:0]          row_cur;
    logic [CW1-1:0]         col_inc;
    logic [RW1-1:0]         row_inc;
    logic [CW-1:0]          col_next;
    logic [RW-1:0]          row_next;
    logic                   pix_xfer;
    logic                   res_xfer;
    logic                   run_last;
    logic [PIXEL_BITS-1:0]  above;
    logic [SC_W-1:0]        wx0;
    logic [SC_W-1:0]        wy0;
    logic [DEN_W-1:0]       p00;
    logic [DEN_W-1:0]       p01;
    logic [DEN_W-1:0]       p10;
    logic [DEN_W-1:0]       p11;
    logic [PX_W-1:0]        base_x_full;
    logic [PY_W-1:0]        base_y_full;
    logic [CW-1:0]          lb_addr;
    alu_ctrl_t              alu_ctrl;
    logic [PIXEL_BITS-1:0]  quotient;

    // effective register values
    always_comb
    begin
        if (scale_x_reg == '0)
            sx_eff = SC_W'(1);
        else if (scale_x_reg > SCALE_W'(MAX_SCALE))
            sx_eff = SC_W'(MAX_SCALE);
        else
            sx_eff = SC_W'(scale_x_reg);

        if (scale_y_reg == '0)
            sy_eff = SC_W'(1);
        else if (scale_y_reg > SCALE_W'(MAX_SCALE))
            sy_eff = SC_W'(MAX_SCALE);
        else
            sy_eff = SC_W'(scale_y_reg);
    end

    assign rw_ext = EW'(row_width_reg);

    always_comb
    begin
        if (rw_ext < EW'(2))
            width_eff = CW1'(2);
        else if (rw_ext > EW'(MAX_WIDTH))
            width_eff = CW1'(MAX_WIDTH);
        else
            width_eff = CW1'(rw_ext);
    end

    // position of the incoming pixel and of the one after it
    assign col_cur = pix.frame_start ? '0 : col_reg;
    assign row_cur = pix.frame_start ? '0 : row_reg;
    assign col_inc = CW1'(col_cur) + CW1'(1);
    assign row_inc = RW1'(row_cur) + RW1'(1);

    always_comb
    begin
        if (col_inc >= width_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= RW1'(MAX_HEIGHT)) ? '0 : RW'(row_inc);
        end
        else
        begin
            col_next = CW'(col_inc);
            row_next = row_cur;
        end
    end

    assign pix_xfer = pix.valid && pix.ready;
    assign res_xfer = res.valid && res.ready;
    assign run_last = (i_reg == sy_reg - SC_W'(1)) && (j_reg == sx_reg - SC_W'(1));

    assign lb_addr = (state_reg == S_IDLE) ? col_cur : cur_col_reg;

    bliu_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (pix_xfer),
        .wr_en (state_reg == S_READ),
        .addr  (lb_addr),
        .wdata (px_reg),
        .rdata (above)
    );

    // corner weights, doubled for the half-up rounding
    assign wx0 = sx_reg - j_reg;
    assign wy0 = sy_reg - i_reg;
    assign p00 = DEN_W'(wx0) * DEN_W'(wy0);
    assign p01 = DEN_W'(j_reg) * DEN_W'(wy0);
    assign p10 = DEN_W'(wx0) * DEN_W'(i_reg);
    assign p11 = DEN_W'(j_reg) * DEN_W'(i_reg);

    assign base_x_full = PX_W'(cur_col_reg - CW'(1)) * PX_W'(sx_reg);
    assign base_y_full = PY_W'(cur_row_reg - RW'(1)) * PY_W'(sy_reg);

    always_comb
    begin
        alu_ctrl.op     = ALU_HOLD;
        alu_ctrl.coef   = coef_reg[k_reg];
        alu_ctrl.weight = w_reg[k_reg];
        alu_ctrl.denom  = d_reg;
        case (state_reg)
            S_WGT:   alu_ctrl.op = ALU_LOAD;
            S_MAC:   alu_ctrl.op = ALU_MAC;
            S_DIV:   alu_ctrl.op = ALU_DIV;
            default: alu_ctrl.op = ALU_HOLD;
        endcase
    end

    bliu_alu u_alu (
        .clk      (clk),
        .ctrl     (alu_ctrl),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (pix.valid) state_next = S_READ;
            S_READ: state_next = emit_reg ? S_WGT : S_IDLE;
            S_WGT:  state_next = S_MAC;
            S_MAC:  if (k_reg == 2'd3) state_next = S_DIV;
            S_DIV:  if (step_reg == STEP_W'(PIXEL_BITS - 1)) state_next = S_OUT;
            S_OUT:  if (res.ready) state_next = run_last ? S_IDLE : S_WGT;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_width_reg <= ROW_WIDTH_RST;
            scale_x_reg   <= SCALE_X_RST;
            scale_y_reg   <= SCALE_Y_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            left_cur_reg  <= '0;
            left_abv_reg  <= '0;
            emit_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROW_WIDTH: row_width_reg <= cfg_data;
                    REG_SCALE_X:   scale_x_reg   <= cfg_data[SCALE_W-1:0];
                    REG_SCALE_Y:   scale_y_reg   <= cfg_data[SCALE_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pix_xfer)
                    begin
                        col_reg  <= col_next;
                        row_reg  <= row_next;
                        emit_reg <= (row_cur != '0) && (col_cur != '0);
                    end
                end
                S_READ:
                begin
                    left_abv_reg <= above;
                    left_cur_reg <= px_reg;
                    i_reg        <= '0;
                    j_reg        <= '0;
                end
                S_WGT:
                begin
                    k_reg <= '0;
                end
                S_MAC:
                begin
                    k_reg    <= k_reg + 2'd1;
                    step_reg <= '0;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                end
                S_OUT:
                begin
                    if (res.ready && !run_last)
                    begin
                        if (j_reg == sx_reg - SC_W'(1))
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + SC_W'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + SC_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // cell payload
    always_ff @(posedge clk)
    begin
        if (pix_xfer)
        begin
            px_reg      <= pix.pixel;
            cur_col_reg <= col_cur;
            cur_row_reg <= row_cur;
            sx_reg      <= sx_eff;
            sy_reg      <= sy_eff;
        end
        if (state_reg == S_READ)
        begin
            coef_reg[0] <= left_abv_reg;
            coef_reg[1] <= above;
            coef_reg[2] <= left_cur_reg;
            coef_reg[3] <= px_reg;
            d_reg       <= DEN_W'(sx_reg) * DEN_W'(sy_reg);
            base_x_reg  <= COORD_W'(base_x_full);
            base_y_reg  <= COORD_W'(base_y_full);
        end
        if (state_reg == S_WGT)
        begin
            w_reg[0] <= {p00, 1'b0};
            w_reg[1] <= {p01, 1'b0};
            w_reg[2] <= {p10, 1'b0};
            w_reg[3] <= {p11, 1'b0};
        end
    end

    assign pix.ready = (state_reg == S_IDLE);
    assign res.valid = (state_reg == S_OUT);
    assign res.value = quotient;
    assign res.out_x = base_x_reg + COORD_W'(j_reg);
    assign res.out_y = base_y_reg + COORD_W'(i_reg);
    assign res.last  = run_last;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !pix.ready)
        else $error("input taken while a result is pending");

    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer |=> (state_reg == S_READ))
        else $error("line store read not started after pixel transfer");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (res_xfer && res.last) |=> pix.ready)
        else $error("block not ready after the final result of a cell");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> ((i_reg < sy_reg) && (j_reg < sx_reg)))
        else $error("output index outside the cell");

endmodule

[dv/bilinear_integer_upscaler_test.sv]
// self-checking testbench for the bilinear integer upscaler: directed table, random frames
`timescale 1ns / 100ps

module bilinear_integer_upscaler_test;
    import bliu_pkg::*;

    localparam int RANDOM_ITEMS  = 360;
    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_PCT      = 34;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] value;
        logic [COORD_W-1:0]    out_x;
        logic [COORD_W-1:0]    out_y;
        logic                  last;
    } up_result_t;

    typedef enum logic [1:0] {
        ST_PIXEL,
        ST_WRITE
    } step_kind_t;

    typedef struct {
        step_kind_t           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          data;
        logic                 fs;
        bit                   typed;
        up_result_t           want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bliu_pix_if pix ();
    bliu_res_if res ();

    bilinear_integer_upscaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .res       (res)
    );

    always #5 clk = ~clk;

    // shadow of the block: registers, line store, counters, left neighbors
    logic [ROW_WIDTH_W-1:0] width_reg;
    logic [SCALE_W-1:0]     sx_reg;
    logic [SCALE_W-1:0]     sy_reg;
    logic [PIXEL_BITS-1:0]  line_mem [MAX_WIDTH_DEF];
    int unsigned            col_q;
    int unsigned            row_q;
    logic [PIXEL_BITS-1:0]  left_cur;
    logic [PIXEL_BITS-1:0]  left_abv;

    up_result_t expected_px[$];
    up_result_t head;
    plan_row_t  plan[$];
    int         fails = 0;
    bit         calm = 1'b0;

    function automatic int unsigned scale_in_use(logic [SCALE_W-1:0] s);
        if (s < 1) return 1;
        if (s > MAX_SCALE) return MAX_SCALE;
        return 32'(s);
    endfunction

    function automatic int unsigned width_in_use();
        if (width_reg < 2) return 2;
        if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return 32'(width_reg);
    endfunction

    function automatic void interpolate_pixel(logic [PIXEL_BITS-1:0] px, logic fs);
        int unsigned sx, sy, w, c, r, i, j;
        logic [PIXEL_BITS-1:0] above;
        longint unsigned c0, c1, c2, c3, num, d;
        up_result_t o;
        sx = scale_in_use(sx_reg);
        sy = scale_in_use(sy_reg);
        w = width_in_use();
        if (fs)
        begin
            col_q = 0;
            row_q = 0;
        end
        c = col_q;
        r = row_q;
        if (c >= MAX_WIDTH_DEF)
            c = 0;
        above = line_mem[c];
        if (r >= 1 && c >= 1)
        begin
            c0 = 64'(left_abv);
            c1 = 64'(above);
            c2 = 64'(left_cur);
            c3 = 64'(px);
            d = 64'(sx) * 64'(sy);
            for (i = 0; i < sy; i++)
            begin
                for (j = 0; j < sx; j++)
                begin
                    num = c0 * (sx - j) * (sy - i) + c1 * j * (sy - i)
                        + c2 * (sx - j) * i + c3 * j * i;
                    o.value = PIXEL_BITS'((2 * num + d) / (2 * d));
                    o.out_x = COORD_W'((c - 1) * sx + j);
                    o.out_y = COORD_W'((r - 1) * sy + i);
                    o.last  = (i == sy - 1) && (j == sx - 1);
                    expected_px.push_back(o);
                end
            end
        end
        line_mem[c] = px;
        left_abv = above;
        left_cur = px;
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= MAX_HEIGHT_DEF)
                r = 0;
        end
        col_q = c;
        row_q = r;
    endfunction

    function automatic void plan_px(logic [15:0] px, logic fs);
        plan_row_t row;
        row.kind  = ST_PIXEL;
        row.idx   = '0;
        row.data  = px;
        row.fs    = fs;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_px_want(logic [15:0] px, logic [15:0] v,
                                         int unsigned x, int unsigned y);
        plan_row_t row;
        row.kind  = ST_PIXEL;
        row.idx   = '0;
        row.data  = px;
        row.fs    = 1'b0;
        row.typed = 1'b1;
        row.want  = '{value: v, out_x: COORD_W'(x), out_y: COORD_W'(y), last: 1'b1};
        plan.push_back(row);
    endfunction

    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        plan_row_t row;
        row.kind  = ST_WRITE;
        row.idx   = idx;
        row.data  = data;
        row.fs    = 1'b0;
        row.typed = 1'b0;
        row.want  = '0;
        plan.push_back(row);
    endfunction

    function automatic logic [15:0] rand_pixel();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 12) return 16'h0000;
        if (pick < 24) return 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic logic [ROW_WIDTH_W-1:0] rand_width();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5) return ROW_WIDTH_W'($urandom_range(0, 1));
        if (pick < 9) return ROW_WIDTH_W'($urandom_range(1025, 2047));
        if (pick < 20) return ROW_WIDTH_W'($urandom_range(9, 24));
        return ROW_WIDTH_W'($urandom_range(2, 8));
    endfunction

    function automatic logic [SCALE_W-1:0] rand_scale();
        if ($urandom_range(99) < 75) return SCALE_W'($urandom_range(1, 3));
        return SCALE_W'($urandom_range(0, 15));
    endfunction

    task automatic send_pixel(input logic [15:0] px, input logic fs);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            pix.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        pix.valid       <= 1'b1;
        pix.pixel       <= px;
        pix.frame_start <= fs;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        interpolate_pixel(px, fs);
    endtask

    task automatic settle();
        pix.valid <= 1'b0;
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ROW_WIDTH: width_reg = data;
            REG_SCALE_X:   sx_reg = data[SCALE_W-1:0];
            REG_SCALE_Y:   sy_reg = data[SCALE_W-1:0];
            default:       ;
        endcase
        @(posedge clk);
    endtask

    // receiver side
    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_px.size() == 0)
            begin
                $error("unexpected transfer: value %0h out_x %0d out_y %0d",
                       res.value, res.out_x, res.out_y);
                fails++;
            end
            else
            begin
                head = expected_px.pop_front();
                if (res.value !== head.value)
                begin
                    $error("value: expected %0h, got %0h", head.value, res.value);
                    fails++;
                end
                if (res.out_x !== head.out_x)
                begin
                    $error("out_x: expected %0d, got %0d", head.out_x, res.out_x);
                    fails++;
                end
                if (res.out_y !== head.out_y)
                begin
                    $error("out_y: expected %0d, got %0d", head.out_y, res.out_y);
                    fails++;
                end
                if (res.last !== head.last)
                begin
                    $error("last: expected %0b, got %0b", head.last, res.last);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        #60_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int unsigned k, n, w, shift_at, phase, random_sent;
        plan_row_t row;

        pix.valid       <= 1'b0;
        pix.pixel       <= '0;
        pix.frame_start <= 1'b0;
        width_reg = ROW_WIDTH_RST;
        sx_reg    = SCALE_X_RST;
        sy_reg    = SCALE_Y_RST;
        for (k = 0; k < MAX_WIDTH_DEF; k++)
            line_mem[k] = '0;
        col_q    = 0;
        row_q    = 0;
        left_cur = '0;
        left_abv = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // width 3 at 1x1: each closing pixel returns its upper-left corner
        plan_reg(REG_ROW_WIDTH, 16'd3);
        plan_reg(REG_SCALE_X, 16'd1);
        plan_reg(REG_SCALE_Y, 16'd1);
        plan_reg(REG_UNUSED, 16'h07FF);
        plan_px(16'hFFFF, 1'b1);
        plan_px(16'h0000, 1'b0);
        plan_px(16'h1234, 1'b0);
        plan_px(16'hABCD, 1'b0);
        plan_px_want(16'h0001, 16'hFFFF, 0, 0);
        plan_px_want(16'hFFFF, 16'h0000, 1, 0);
        plan_px(16'h8000, 1'b0);
        plan_px_want(16'h7FFF, 16'hABCD, 0, 1);
        plan_px_want(16'h5555, 16'h0001, 1, 1);
        // frame restart at the start of a row
        plan_px(16'hAAAA, 1'b1);
        plan_px(16'h0F0F, 1'b0);
        plan_px(16'hF0F0, 1'b0);
        plan_px(16'h1111, 1'b0);
        plan_px_want(16'h2222, 16'hAAAA, 0, 0);
        // out-of-range scales, changed mid-frame
        plan_reg(REG_SCALE_X, 16'd15);
        plan_reg(REG_SCALE_Y, 16'd0);
        plan_px(16'h3333, 1'b0);
        plan_reg(REG_SCALE_X, 16'd0);
        plan_reg(REG_SCALE_Y, 16'd15);
        plan_px(16'h4444, 1'b0);
        plan_px(16'h5555, 1'b0);
        // width shrunk below the current column
        plan_reg(REG_ROW_WIDTH, 16'd1);
        plan_px(16'h6666, 1'b0);
        plan_px(16'h7777, 1'b0);
        plan_px(16'h0000, 1'b0);
        plan_reg(REG_ROW_WIDTH, 16'd2047);
        plan_px(16'hFFFF, 1'b1);

        foreach (plan[k])
        begin
            row = plan[k];
            if (row.kind == ST_WRITE)
            begin
                settle();
                write_reg(row.idx, CFG_DATA_W'(row.data));
            end
            else
            begin
                send_pixel(row.data, row.fs);
                if (row.typed)
                begin
                    expected_px.delete(expected_px.size() - 1);
                    expected_px.push_back(row.want);
                end
            end
        end
        settle();

        phase = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            calm = (phase >= 8 && phase < 12);
            write_reg(REG_ROW_WIDTH, rand_width());
            write_reg(REG_SCALE_X, CFG_DATA_W'(rand_scale()));
            write_reg(REG_SCALE_Y, CFG_DATA_W'(rand_scale()));
            if ($urandom_range(9) == 0)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            w = width_in_use();
            if (w > 24)
                n = $urandom_range(3, 12);
            else
                n = w * $urandom_range(2, 4) + $urandom_range(0, w - 1);
            if (n > RANDOM_ITEMS - random_sent)
                n = RANDOM_ITEMS - random_sent;
            shift_at = ($urandom_range(4) == 0) ? n / 2 : n + 1;
            for (k = 0; k < n; k++)
            begin
                if (k == shift_at)
                begin
                    settle();
                    write_reg(REG_ROW_WIDTH, rand_width());
                    write_reg(REG_SCALE_X, CFG_DATA_W'(rand_scale()));
                    write_reg(REG_SCALE_Y, CFG_DATA_W'(rand_scale()));
                end
                send_pixel(rand_pixel(), (k == 0) || ($urandom_range(29) == 0));
                random_sent++;
            end
            settle();
            phase++;
        end
        calm = 1'b0;

        if (fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
